>>> hw/rtl/tpqm_pkg.sv
// Types and constants shared by the touch press qualify and map block.
package tpqm_pkg;

   localparam int RAW_WIDTH      = 13;
   localparam int COEF_WIDTH     = 32;
   localparam int THR_WIDTH      = 13;
   localparam int HOLD_WIDTH     = 8;
   localparam int SCREEN_WIDTH   = 16;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int PROD_WIDTH     = COEF_WIDTH + RAW_WIDTH + 1;
   localparam int ACC_WIDTH      = PROD_WIDTH + 2;
   localparam int FRAC_BITS      = 16;

   localparam logic [HOLD_WIDTH-1:0] HOLD_SAMPLES      = HOLD_WIDTH'(3);
   localparam logic [RAW_WIDTH-1:0]  ABSENT_CODE       = '1;
   localparam logic [THR_WIDTH-1:0]  THRESHOLD_DEFAULT = THR_WIDTH'(400);
   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF  = ACC_WIDTH'(1 << (FRAC_BITS - 1));

   typedef enum logic [2:0] {
      CSR_CALIBRATED   = 3'd0,
      CSR_THRESHOLD    = 3'd1,
      CSR_GAIN_XX      = 3'd2,
      CSR_GAIN_XY      = 3'd3,
      CSR_OFFSET_X     = 3'd4,
      CSR_GAIN_YX      = 3'd5,
      CSR_GAIN_YY      = 3'd6,
      CSR_OFFSET_Y     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [RAW_WIDTH-1:0] raw_x;
      logic [RAW_WIDTH-1:0] raw_y;
      logic [RAW_WIDTH-1:0] pressure;
   } req_word_type;

   typedef struct packed {
      logic                    status;
      logic                    press_event;
      logic                    release_event;
      logic                    coords_updated;
      logic [SCREEN_WIDTH-1:0] screen_x;
      logic [SCREEN_WIDTH-1:0] screen_y;
   } rsp_word_type;

   typedef struct packed {
      logic status;
      logic press;
      logic rel;
      logic updated;
   } flags_type;

endpackage

>>> hw/rtl/tpqm_req_if.sv
// Valid/ready channel carrying one touch sample word.
interface tpqm_req_if;
   import tpqm_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/tpqm_rsp_if.sv
// Valid/ready channel carrying one touch result word.
interface tpqm_rsp_if;
   import tpqm_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/touch_press_qualify_and_map.sv
// Touch press qualification and affine mapping of raw samples to screen coordinates.
//
// Takes one touch sample word per clock unless the result channel stalls, and returns
// one result word for each, in order. The press/release decision and hold counter
// update are made at acceptance, the four 32x13 coefficient products are registered in
// the second stage, and the sum, rounding and saturation feed the result register in
// the third. Coefficient and threshold registers must only be written while no word is
// in flight.
module touch_press_qualify_and_map (
   input  logic                                 clock,
   input  logic                                 reset,
   tpqm_req_if.sink                             req_bus,
   tpqm_rsp_if.source                           rsp_bus,
   input  logic                                 csr_write_enable,
   input  tpqm_pkg::csr_index_type              csr_index,
   input  logic [tpqm_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import tpqm_pkg::*;

   // configuration
   logic                          calibrated_ff;
   logic [THR_WIDTH-1:0]          threshold_ff;
   logic signed [COEF_WIDTH-1:0]  gain_xx_ff, gain_xy_ff, offset_x_ff;
   logic signed [COEF_WIDTH-1:0]  gain_yx_ff, gain_yy_ff, offset_y_ff;

   // state
   logic [HOLD_WIDTH-1:0]         hold_ff, hold_in;
   logic [SCREEN_WIDTH-1:0]       last_x_ff, last_y_ff;

   // stage 1
   logic                          s1_valid_ff;
   logic [RAW_WIDTH-1:0]          s1_raw_x_ff, s1_raw_y_ff;
   flags_type                     s1_flags_ff, s1_flags_in;

   // stage 2
   logic                          s2_valid_ff;
   flags_type                     s2_flags_ff;
   logic signed [PROD_WIDTH-1:0]  p_xx_ff, p_xy_ff, p_yx_ff, p_yy_ff;

   // result
   logic                          rsp_valid_ff;
   rsp_word_type                  rsp_word_ff, rsp_word_in;

   logic                          rsp_load, s2_load, req_ready, req_acc;
   logic                          touch;
   logic signed [ACC_WIDTH-1:0]   acc_x, acc_y;
   logic [SCREEN_WIDTH-1:0]       map_x, map_y;

   function automatic logic [SCREEN_WIDTH-1:0] round_sat(input logic signed [ACC_WIDTH-1:0] acc);
      logic [SCREEN_WIDTH-1:0] res;
      if (acc[ACC_WIDTH-1]) begin
         res = '0;
      end else if (|acc[ACC_WIDTH-2:FRAC_BITS+SCREEN_WIDTH]) begin
         res = '1;
      end else begin
         res = acc[FRAC_BITS+SCREEN_WIDTH-1:FRAC_BITS];
      end
      return res;
   endfunction

   // handshake
   assign rsp_load  = s2_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign s2_load   = s1_valid_ff && (!s2_valid_ff || rsp_load);
   assign req_ready = !s1_valid_ff || s2_load;
   assign req_acc   = req_bus.valid && req_ready;

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_word_ff;

   // qualification at acceptance
   assign touch = req_bus.data.pressure > threshold_ff;

   always_comb begin
      hold_in     = hold_ff;
      s1_flags_in = '0;
      if (!touch) begin
         hold_in         = HOLD_SAMPLES;
         s1_flags_in.rel = 1'b1;
      end else if (req_bus.data.pressure == ABSENT_CODE) begin
         s1_flags_in.status = 1'b1;
      end else if (hold_ff != '0) begin
         hold_in               = hold_ff - HOLD_WIDTH'(1);
         s1_flags_in.press     = (hold_in == '0);
         s1_flags_in.updated   = (hold_in == '0) && calibrated_ff;
      end
   end

   // final sum, rounding and saturation
   assign acc_x = ACC_WIDTH'(p_xx_ff) + ACC_WIDTH'(p_xy_ff) + ACC_WIDTH'(offset_x_ff) + ROUND_HALF;
   assign acc_y = ACC_WIDTH'(p_yx_ff) + ACC_WIDTH'(p_yy_ff) + ACC_WIDTH'(offset_y_ff) + ROUND_HALF;
   assign map_x = round_sat(acc_x);
   assign map_y = round_sat(acc_y);

   always_comb begin
      rsp_word_in.status         = s2_flags_ff.status;
      rsp_word_in.press_event    = s2_flags_ff.press;
      rsp_word_in.release_event  = s2_flags_ff.rel;
      rsp_word_in.coords_updated = s2_flags_ff.updated;
      rsp_word_in.screen_x       = s2_flags_ff.updated ? map_x : last_x_ff;
      rsp_word_in.screen_y       = s2_flags_ff.updated ? map_y : last_y_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         calibrated_ff <= 1'b0;
         threshold_ff  <= THRESHOLD_DEFAULT;
         gain_xx_ff    <= '0;
         gain_xy_ff    <= '0;
         offset_x_ff   <= '0;
         gain_yx_ff    <= '0;
         gain_yy_ff    <= '0;
         offset_y_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CALIBRATED: calibrated_ff <= csr_write_data[0];
            CSR_THRESHOLD:  threshold_ff  <= csr_write_data[THR_WIDTH-1:0];
            CSR_GAIN_XX:    gain_xx_ff    <= csr_write_data;
            CSR_GAIN_XY:    gain_xy_ff    <= csr_write_data;
            CSR_OFFSET_X:   offset_x_ff   <= csr_write_data;
            CSR_GAIN_YX:    gain_yx_ff    <= csr_write_data;
            CSR_GAIN_YY:    gain_yy_ff    <= csr_write_data;
            CSR_OFFSET_Y:   offset_y_ff   <= csr_write_data;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= HOLD_WIDTH'(1);
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            hold_ff <= hold_in;
         end
         if (rsp_load) begin
            last_x_ff <= rsp_word_in.screen_x;
            last_y_ff <= rsp_word_in.screen_y;
         end
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            s2_valid_ff <= 1'b1;
         end else if (rsp_load) begin
            s2_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_raw_x_ff <= req_bus.data.raw_x;
         s1_raw_y_ff <= req_bus.data.raw_y;
         s1_flags_ff <= s1_flags_in;
      end
      if (s2_load) begin
         s2_flags_ff <= s1_flags_ff;
         p_xx_ff     <= gain_xx_ff * $signed({1'b0, s1_raw_x_ff});
         p_xy_ff     <= gain_xy_ff * $signed({1'b0, s1_raw_y_ff});
         p_yx_ff     <= gain_yx_ff * $signed({1'b0, s1_raw_x_ff});
         p_yy_ff     <= gain_yy_ff * $signed({1'b0, s1_raw_y_ff});
      end
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule
